### rtl/e2c_pkg.sv
`timescale 1ns / 1ps
package e2c_pkg;

  // Field widths
  localparam int MS_W     = 45;   // input timestamp
  localparam int T_W      = 46;   // biased timestamp
  localparam int DAYS_W   = 20;   // biased day count
  localparam int REM_W    = 27;   // millisecond of the day
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int MSEC_W   = 10;
  localparam int ZONE_W   = 6;

  // Time constants
  localparam int MS_PER_HOUR   = 3600000;
  localparam int MS_PER_MINUTE = 60000;
  localparam int MS_PER_SECOND = 1000;

  // Two days of bias keep the sum non-negative for any offset
  localparam int HOUR_BIAS = 48;
  localparam int BIAS_DAYS = 2;

  // One day is 2^10 * DAY_HI milliseconds
  localparam int DAY_LO_W = 10;
  localparam int DAY_HI   = 84375;
  localparam int DAY_X_W  = T_W - DAY_LO_W;       // 36
  localparam int DAY_RECIP_W = 20;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP =
    DAY_RECIP_W'((64'd1 << DAY_X_W) / 64'd84375);

  // Calendar constants
  localparam int EPOCH_SHIFT  = 719468;
  localparam int SHIFT_DAYS   = EPOCH_SHIFT - BIAS_DAYS;
  localparam int ERA_DAYS     = 146097;
  localparam int ERA_LAST     = 146096;
  localparam int DAYS_4YR     = 1460;
  localparam int DAYS_100YR   = 36524;
  localparam int DAYS_PER_YR  = 365;
  localparam int YEARS_PER_ERA = 400;

  localparam int SHIFTED_W = 21;
  localparam int ERA_W     = 4;
  localparam int DOE_W     = 18;
  localparam int YOE_W     = 9;
  localparam int DOY_W     = 9;
  localparam int MP_W      = 4;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // First day of each March-based month within the year
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // March-based month: count of month starts at or below the day of year
  function automatic logic [MP_W-1:0] month_index(input logic [DOY_W-1:0] doy);
    logic [MP_W-1:0] cnt;
    cnt = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= month_start(MP_W'(k))) cnt = cnt + 4'd1;
    end
    return cnt;
  endfunction

  // Day of era divided by the days of a century
  function automatic logic [2:0] cent_count(input logic [DOE_W-1:0] doe);
    logic [2:0] cnt;
    cnt = '0;
    for (int k = 1; k < 5; k++) begin
      if (doe >= DOE_W'(k * DAYS_100YR)) cnt = cnt + 3'd1;
    end
    return cnt;
  endfunction

  // Year of era divided by one hundred
  function automatic logic [1:0] yoe_div100(input logic [YOE_W-1:0] yoe);
    logic [1:0] cnt;
    cnt = '0;
    for (int k = 1; k < 4; k++) begin
      if (yoe >= YOE_W'(k * 100)) cnt = cnt + 2'd1;
    end
    return cnt;
  endfunction

endpackage

### rtl/e2c_cdiv.sv
`timescale 1ns / 1ps
module e2c_cdiv #(
  parameter int XW = 18,
  parameter int QW = 7,
  parameter int D  = 1460,
  parameter int S  = 18,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [XW-1:0]        x_i,
  input  logic [SW-1:0]        side_i,
  output logic                 vld_o,
  output logic [QW-1:0]        q_o,
  output logic [$clog2(D)-1:0] r_o,
  output logic [SW-1:0]        side_o
);

  localparam int M  = (1 << S) / D;
  localparam int MW = $clog2(M + 1);
  localparam int PW = XW + MW;
  localparam int RW = $clog2(D);
  localparam logic [XW-1:0] DX = XW'(D);
  localparam logic [PW-1:0] MX = PW'(M);

  logic          v1_r, v2_r, v3_r;
  logic [XW-1:0] x1_r;
  logic [QW-1:0] qe1_r, qe1_nxt;
  logic [SW-1:0] side1_r, side2_r, side3_r;
  logic [QW-1:0] qe2_r;
  logic [XW-1:0] r2_r, r2_nxt;
  logic [QW-1:0] q3_r, q3_nxt;
  logic [RW-1:0] r3_r, r3_nxt;
  logic [PW-1:0] prod;
  logic          fix;

  // Estimate the quotient by the scaled reciprocal, low by at most one
  always_comb begin
    prod    = PW'(x_i) * MX;
    qe1_nxt = QW'(prod >> S);
  end

  // Remainder of the estimate, below twice the divisor
  assign r2_nxt = x1_r - XW'(qe1_r) * DX;

  // Correct the estimate once
  always_comb begin
    fix    = (r2_r >= DX);
    q3_nxt = fix ? qe2_r + 1'b1 : qe2_r;
    r3_nxt = fix ? RW'(r2_r - DX) : RW'(r2_r);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x_i;
      qe1_r   <= qe1_nxt;
      side1_r <= side_i;
      qe2_r   <= qe1_r;
      r2_r    <= r2_nxt;
      side2_r <= side1_r;
      q3_r    <= q3_nxt;
      r3_r    <= r3_nxt;
      side3_r <= side2_r;
    end
  end

  assign vld_o  = v3_r;
  assign q_o    = q3_r;
  assign r_o    = r3_r;
  assign side_o = side3_r;

endmodule

### rtl/e2c_front.sv
`timescale 1ns / 1ps
module e2c_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        vld_i,
  input  logic [e2c_pkg::MS_W-1:0]    ms_i,
  input  logic signed [e2c_pkg::ZONE_W-1:0] zone_i,
  output logic                        vld_o,
  output logic [e2c_pkg::DAYS_W-1:0]  days_o,
  output logic [e2c_pkg::REM_W-1:0]   rem_o
);
  import e2c_pkg::*;

  localparam int HALF_W = DAY_X_W / 2;
  localparam int PP_W   = HALF_W + DAY_RECIP_W;
  localparam int SUM_W  = DAY_X_W + DAY_RECIP_W;
  localparam int R_W    = 18;   // remainder below twice DAY_HI

  logic                  v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [T_W-1:0]        t1_r, t1_nxt;
  logic [6:0]            hrs;
  logic [DAY_X_W-1:0]    x2_r, x3_r;
  logic [DAY_LO_W-1:0]   lo2_r, lo3_r, lo4_r;
  logic [PP_W-1:0]       phi2_r, plo2_r;
  logic [SUM_W-1:0]      sum;
  logic [DAYS_W-1:0]     qe3_r, qe4_r;
  logic [R_W-1:0]        r4_r, r4_nxt;
  logic [DAYS_W-1:0]     days5_r, days5_nxt;
  logic [REM_W-1:0]      rem5_r, rem5_nxt;
  logic                  fix;

  // Add the zone offset plus two days of bias
  always_comb begin
    hrs    = 7'(HOUR_BIAS) + {zone_i[ZONE_W-1], zone_i};
    t1_nxt = T_W'(ms_i) + T_W'(hrs) * T_W'(MS_PER_HOUR);
  end

  // Estimate the day count from two partial products
  assign sum = {phi2_r, {HALF_W{1'b0}}} + SUM_W'(plo2_r);

  // Remainder of the estimate
  assign r4_nxt = R_W'(x3_r - DAY_X_W'(qe3_r) * DAY_X_W'(DAY_HI));

  // Correct the estimate, rebuild the millisecond of the day
  always_comb begin
    fix       = (r4_r >= R_W'(DAY_HI));
    days5_nxt = fix ? qe4_r + 1'b1 : qe4_r;
    rem5_nxt  = fix ? {17'(r4_r - R_W'(DAY_HI)), lo4_r} : {17'(r4_r), lo4_r};
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      t1_r    <= t1_nxt;
      x2_r    <= t1_r[T_W-1:DAY_LO_W];
      lo2_r   <= t1_r[DAY_LO_W-1:0];
      phi2_r  <= PP_W'(t1_r[T_W-1:DAY_LO_W+HALF_W]) * PP_W'(DAY_RECIP);
      plo2_r  <= PP_W'(t1_r[DAY_LO_W+HALF_W-1:DAY_LO_W]) * PP_W'(DAY_RECIP);
      x3_r    <= x2_r;
      lo3_r   <= lo2_r;
      qe3_r   <= sum[SUM_W-1:DAY_X_W];
      qe4_r   <= qe3_r;
      r4_r    <= r4_nxt;
      lo4_r   <= lo3_r;
      days5_r <= days5_nxt;
      rem5_r  <= rem5_nxt;
    end
  end

  assign vld_o  = v5_r;
  assign days_o = days5_r;
  assign rem_o  = rem5_r;

endmodule

### rtl/e2c_cal.sv
`timescale 1ns / 1ps
module e2c_cal (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [e2c_pkg::DAYS_W-1:0] days_i,
  input  logic [e2c_pkg::REM_W-1:0]  rem_i,
  output logic                       vld_o,
  output e2c_pkg::date_t             date_o,
  output logic [e2c_pkg::REM_W-1:0]  rem_o
);
  import e2c_pkg::*;

  localparam int CSW = REM_W + ERA_W + DOE_W;

  logic                  v0_r, va_r, vd_r, vm_r, vo_r;
  logic [SHIFTED_W-1:0]  shifted_r;
  logic [REM_W-1:0]      rem0_r;

  logic                  v_era;
  logic [ERA_W-1:0]      era_q;
  logic [DOE_W-1:0]      doe_q;
  logic [REM_W-1:0]      rem_q;

  logic                  v_c4;
  logic [6:0]            q1460;
  logic [CSW-1:0]        side_c4;
  logic [DOE_W-1:0]      doe_c4;

  logic [DOE_W-1:0]      a_r, a_nxt;
  logic [CSW-1:0]        side_a_r;

  logic                  v_y;
  logic [YOE_W-1:0]      yoe_q;
  logic [CSW-1:0]        side_y;
  logic [REM_W-1:0]      rem_y;
  logic [ERA_W-1:0]      era_y;
  logic [DOE_W-1:0]      doe_y;

  logic [DOY_W-1:0]      doy_r, doy_nxt, doy_m_r;
  logic [YOE_W-1:0]      yoe_d_r, yoe_m_r;
  logic [ERA_W-1:0]      era_d_r, era_m_r;
  logic [REM_W-1:0]      rem_d_r, rem_m_r, rem_o_r;
  logic [MP_W-1:0]       mp_r;

  date_t                 date_r, date_nxt;
  logic [YEAR_W:0]       year_full;

  // Shift the day count to the March-based calendar
  always_ff @(posedge clk) begin
    if (en) begin
      shifted_r <= SHIFTED_W'(days_i) + SHIFTED_W'(SHIFT_DAYS);
      rem0_r    <= rem_i;
    end
  end

  // Split into era and day of era
  e2c_cdiv #(
    .XW(SHIFTED_W), .QW(ERA_W), .D(ERA_DAYS), .S(SHIFTED_W), .SW(REM_W)
  ) u_era (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(v0_r), .x_i(shifted_r), .side_i(rem0_r),
    .vld_o(v_era), .q_o(era_q), .r_o(doe_q), .side_o(rem_q)
  );

  // Leap-day count of four-year cycles
  e2c_cdiv #(
    .XW(DOE_W), .QW(7), .D(DAYS_4YR), .S(DOE_W), .SW(CSW)
  ) u_c4 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(v_era), .x_i(doe_q), .side_i({rem_q, era_q, doe_q}),
    .vld_o(v_c4), .q_o(q1460), .r_o(), .side_o(side_c4)
  );

  assign doe_c4 = side_c4[DOE_W-1:0];

  // Remove leap days so the year divides evenly
  assign a_nxt = doe_c4 - DOE_W'(q1460) + DOE_W'(cent_count(doe_c4))
               - DOE_W'(doe_c4 == DOE_W'(ERA_LAST));

  always_ff @(posedge clk) begin
    if (en) begin
      a_r      <= a_nxt;
      side_a_r <= side_c4;
    end
  end

  // Year of era
  e2c_cdiv #(
    .XW(DOE_W), .QW(YOE_W), .D(DAYS_PER_YR), .S(DOE_W), .SW(CSW)
  ) u_yr (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(va_r), .x_i(a_r), .side_i(side_a_r),
    .vld_o(v_y), .q_o(yoe_q), .r_o(), .side_o(side_y)
  );

  assign {rem_y, era_y, doe_y} = side_y;

  // Day of the March-based year
  assign doy_nxt = DOY_W'(doe_y - DOE_W'(yoe_q) * DOE_W'(DAYS_PER_YR)
                   - DOE_W'(yoe_q >> 2) + DOE_W'(yoe_div100(yoe_q)));

  // Build year, month and day
  always_comb begin
    date_nxt.day   = DAY_W'(doy_m_r - month_start(mp_r) + 9'd1);
    date_nxt.month = (mp_r < 4'd10) ? mp_r + 4'd3 : mp_r - 4'd9;
    year_full      = (YEAR_W+1)'(yoe_m_r)
                   + (YEAR_W+1)'(era_m_r) * (YEAR_W+1)'(YEARS_PER_ERA)
                   + (YEAR_W+1)'(mp_r >= 4'd10);
    date_nxt.year  = year_full[YEAR_W-1:0];
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      va_r <= 1'b0;
      vd_r <= 1'b0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      v0_r <= vld_i;
      va_r <= v_c4;
      vd_r <= v_y;
      vm_r <= vd_r;
      vo_r <= vm_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      doy_r   <= doy_nxt;
      yoe_d_r <= yoe_q;
      era_d_r <= era_y;
      rem_d_r <= rem_y;
      mp_r    <= month_index(doy_r);
      doy_m_r <= doy_r;
      yoe_m_r <= yoe_d_r;
      era_m_r <= era_d_r;
      rem_m_r <= rem_d_r;
      date_r  <= date_nxt;
      rem_o_r <= rem_m_r;
    end
  end

  assign vld_o  = vo_r;
  assign date_o = date_r;
  assign rem_o  = rem_o_r;

endmodule

### rtl/e2c_clock.sv
`timescale 1ns / 1ps
module e2c_clock (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic [e2c_pkg::REM_W-1:0]    rem_i,
  input  e2c_pkg::date_t               date_i,
  output logic                         vld_o,
  output e2c_pkg::date_t               date_o,
  output logic [e2c_pkg::HOUR_W-1:0]   hour_o,
  output logic [e2c_pkg::MINUTE_W-1:0] minute_o,
  output logic [e2c_pkg::SECOND_W-1:0] second_o,
  output logic [e2c_pkg::MSEC_W-1:0]   msec_o
);
  import e2c_pkg::*;

  localparam int DW    = $bits(date_t);
  localparam int HR_RW = $clog2(MS_PER_HOUR);
  localparam int MN_RW = $clog2(MS_PER_MINUTE);

  logic                v_h, v_m;
  logic [HOUR_W-1:0]   hour_q, hour_m;
  logic [HR_RW-1:0]    rem_h;
  logic [DW-1:0]       date_h;
  logic [MINUTE_W-1:0] minute_q;
  logic [MN_RW-1:0]    rem_m;
  logic [DW-1:0]       date_m;

  // Hour of day
  e2c_cdiv #(
    .XW(REM_W), .QW(HOUR_W), .D(MS_PER_HOUR), .S(REM_W), .SW(DW)
  ) u_hour (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(vld_i), .x_i(rem_i), .side_i(date_i),
    .vld_o(v_h), .q_o(hour_q), .r_o(rem_h), .side_o(date_h)
  );

  // Minute of hour
  e2c_cdiv #(
    .XW(HR_RW), .QW(MINUTE_W), .D(MS_PER_MINUTE), .S(HR_RW), .SW(DW + HOUR_W)
  ) u_minute (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(v_h), .x_i(rem_h), .side_i({date_h, hour_q}),
    .vld_o(v_m), .q_o(minute_q), .r_o(rem_m), .side_o({date_m, hour_m})
  );

  // Second of minute, remainder is the millisecond
  e2c_cdiv #(
    .XW(MN_RW), .QW(SECOND_W), .D(MS_PER_SECOND), .S(MN_RW),
    .SW(DW + HOUR_W + MINUTE_W)
  ) u_second (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(v_m), .x_i(rem_m), .side_i({date_m, hour_m, minute_q}),
    .vld_o(vld_o), .q_o(second_o), .r_o(msec_o),
    .side_o({date_o, hour_o, minute_o})
  );

endmodule

### rtl/epoch_to_civil_datetime.sv
`timescale 1ns / 1ps
// Epoch timestamp to civil date and time converter.
//
// Input request: in_epoch_millis, milliseconds since 1970-01-01 00:00 UTC,
// taken on in_valid & in_ready. Result request: year, month, day, hour,
// minute, second and millisecond, offered on out_valid until out_ready.
// cfg_wr_en writes cfg_wr_data as the signed zone offset in hours, added
// before conversion; write it only while no request is in flight.
//
// One request is accepted every cycle while the output is not stalled:
// a 28-stage pipeline with valid bits, built from a 5-stage day split
// and three-stage reciprocal-multiply dividers for the era, four-year
// cycle, year, hour, minute and second.
// When the receiver stalls with a result pending, the whole pipeline
// holds and in_ready drops; nothing is lost or repeated. A synchronous
// reset clears all valid bits and sets the zone offset to zero.
module epoch_to_civil_datetime (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic signed [e2c_pkg::ZONE_W-1:0]  cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [e2c_pkg::MS_W-1:0]           in_epoch_millis,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [e2c_pkg::YEAR_W-1:0]         out_year,
  output logic [e2c_pkg::MONTH_W-1:0]        out_month,
  output logic [e2c_pkg::DAY_W-1:0]          out_day,
  output logic [e2c_pkg::HOUR_W-1:0]         out_hour,
  output logic [e2c_pkg::MINUTE_W-1:0]       out_minute,
  output logic [e2c_pkg::SECOND_W-1:0]       out_second,
  output logic [e2c_pkg::MSEC_W-1:0]         out_millisecond
);
  import e2c_pkg::*;

  logic signed [ZONE_W-1:0] zone_r;
  logic                     en;
  logic                     v_f, v_c;
  logic [DAYS_W-1:0]        days_f;
  logic [REM_W-1:0]         rem_f, rem_c;
  date_t                    date_c, date_o;

  // Zone offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r <= '0;
    end else if (cfg_wr_en) begin
      zone_r <= cfg_wr_data;
    end
  end

  // Advance the pipeline unless a result is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  e2c_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(in_valid), .ms_i(in_epoch_millis), .zone_i(zone_r),
    .vld_o(v_f), .days_o(days_f), .rem_o(rem_f)
  );

  e2c_cal u_cal (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(v_f), .days_i(days_f), .rem_i(rem_f),
    .vld_o(v_c), .date_o(date_c), .rem_o(rem_c)
  );

  e2c_clock u_clock (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(v_c), .rem_i(rem_c), .date_i(date_c),
    .vld_o(out_valid), .date_o(date_o),
    .hour_o(out_hour), .minute_o(out_minute),
    .second_o(out_second), .msec_o(out_millisecond)
  );

  assign out_year  = date_o.year;
  assign out_month = date_o.month;
  assign out_day   = date_o.day;

`ifndef SYNTHESIS
  a_fields_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day >= 5'd1)
      && (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59)
      && (out_millisecond <= 10'd999))
    else $error("result field out of range");

  a_month_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_day <= 5'd31)
      && ((out_month != 4'd2) || (out_day <= 5'd29))
      && ((out_month != 4'd2) || (out_day != 5'd29) || (out_year[1:0] == 2'd0))
      && (((out_month != 4'd4) && (out_month != 4'd6) && (out_month != 4'd9)
           && (out_month != 4'd11)) || (out_day <= 5'd30)))
    else $error("day beyond the length of its month");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
